// File: hdl/ssdp_header_stream_parser_macros.svh
// assertion macros for the ssdp header stream parser
`ifndef SSDP_HEADER_STREAM_PARSER_MACROS_SVH
`define SSDP_HEADER_STREAM_PARSER_MACROS_SVH
// implication checked on every clock edge outside reset
`define SSDP_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// next-cycle implication outside reset
`define SSDP_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// File: hdl/ssdp_pkg.sv
// package with payload types, phases and constants of the ssdp parser
`timescale 1ns / 1ps
`default_nettype none
package ssdp_pkg;
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] dest_port;
    logic        is_udp;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field_id;
    logic [7:0] value_byte;
    logic [1:0] method;
    logic [1:0] confidence;
    logic       last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_FIRST = 3'd0, PH_NAME = 3'd1, PH_SPACE = 3'd2,
    PH_VALUE = 3'd3, PH_SKIP = 3'd4, PH_DONE = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_SUM   = 2'd2;

  localparam logic [1:0] REG_PORT  = 2'd0;
  localparam logic [1:0] REG_LINES = 2'd1;
  localparam logic [1:0] REG_VALUE = 2'd2;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result queue depth, power of two, room for four results per command
  localparam int OUT_DEPTH = 8;

  // one accepted byte with what it did, passed from front to back
  typedef struct packed {
    logic [7:0] ch;        // accepted byte; a replayed CR is flagged by replay_cr
    logic       replay_cr; // a held CR is content before ch
    logic       eol;       // CR LF closes a line here
    logic       hold_cr;   // ch is CR and is held
    logic       last;
    logic [15:0] dest_port;
    logic       is_udp;
  } cmd_t;

  function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [5:0] p);
    logic [8*19-1:0] s;
    logic [4:0] i;
    begin
      case (k)
        2'd0: s = "M-SEARCH * HTTP/1.1";
        2'd1: s = {"NOTIFY * HTTP/1.1", 16'h0};
        default: s = {"HTTP/1.1", 88'h0};
      endcase
      i = p[4:0];
      pfx_char = s[8*(18 - i) +: 8];
    end
  endfunction

  function automatic logic [5:0] pfx_len(input logic [1:0] k);
    case (k)
      2'd0: pfx_len = 6'd19;
      2'd1: pfx_len = 6'd17;
      default: pfx_len = 6'd8;
    endcase
  endfunction

  function automatic logic [3:0] hdr_len(input logic [2:0] k);
    case (k)
      3'd0: hdr_len = 4'd2;
      3'd1: hdr_len = 4'd2;
      3'd2: hdr_len = 4'd3;
      3'd3: hdr_len = 4'd8;
      3'd4: hdr_len = 4'd6;
      default: hdr_len = 4'd3;
    endcase
  endfunction

  function automatic logic [7:0] hdr_char(input logic [2:0] k, input logic [3:0] p);
    logic [63:0] s;
    begin
      case (k)
        3'd0: s = {"ST", 48'h0};
        3'd1: s = {"NT", 48'h0};
        3'd2: s = {"NTS", 40'h0};
        3'd3: s = "LOCATION";
        3'd4: s = {"SERVER", 16'h0};
        default: s = {"USN", 40'h0};
      endcase
      hdr_char = s[8*(7 - p[2:0]) +: 8];
    end
  endfunction
endpackage
`default_nettype wire

// File: hdl/ssdp_front.sv
// front end: accepts bytes and resolves cr lf pairing into commands
`timescale 1ns / 1ps
`default_nettype none
module ssdp_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire ssdp_pkg::in_item_t in_item,
  output logic                  cmd_valid,
  output ssdp_pkg::cmd_t        cmd,
  input  wire logic             cmd_ready
);
  import ssdp_pkg::*;
  logic pend_cr;

  assign full = !cmd_ready;
  assign cmd_valid = push && cmd_ready;

  always_comb begin
    cmd.ch        = in_item.data_byte;
    cmd.replay_cr = pend_cr && (in_item.data_byte != CH_LF);
    cmd.eol       = pend_cr && (in_item.data_byte == CH_LF);
    cmd.hold_cr   = !cmd.eol && (in_item.data_byte == CH_CR) && !in_item.last_byte;
    cmd.last      = in_item.last_byte;
    cmd.dest_port = in_item.dest_port;
    cmd.is_udp    = in_item.is_udp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cr <= 1'b0;
    end else if (cmd_valid) begin
      pend_cr <= cmd.hold_cr && !cmd.last;
    end
  end
endmodule
`default_nettype wire

// File: hdl/ssdp_cmd_fifo.sv
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module ssdp_cmd_fifo #(
  parameter int Depth = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  input  wire ssdp_pkg::cmd_t wr_data,
  output logic                wr_ready,
  output logic                rd_valid,
  output ssdp_pkg::cmd_t      rd_data,
  input  wire logic           rd_ready
);
  import ssdp_pkg::*;
  localparam int AW = $clog2(Depth);
  cmd_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic wr_en, rd_en;

  assign wr_ready = cnt != AW'(0) + (AW+1)'(Depth);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (wr_en) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule
`default_nettype wire

// File: hdl/ssdp_back.sv
// back end: parser state, result sequencing and result queue
`timescale 1ns / 1ps
`default_nettype none
`include "ssdp_header_stream_parser_macros.svh"
module ssdp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  input  wire ssdp_pkg::cmd_t    cmd,
  output logic                   cmd_ready,
  input  wire logic [15:0]       discovery_port,
  input  wire logic [3:0]        max_header_lines,
  input  wire logic [7:0]        max_value_bytes,
  output logic                   empty,
  input  wire logic              pop,
  output ssdp_pkg::out_item_t    out_item
);
  import ssdp_pkg::*;
  localparam int AW = $clog2(OUT_DEPTH);

  phase_t     phase;
  logic [5:0] fl_len;
  logic [2:0] pfx_ok;
  logic [1:0] meth;
  logic [3:0] hl_cnt;
  logic [3:0] nm_len;
  logic [5:0] nm_ok;
  logic [2:0] sel;
  logic [7:0] vb_cnt;

  // first step: replayed CR content or line end; second step: the byte
  // (or nothing); then summary. each step yields at most one result
  // except the last byte which may give value, end and summary.
  logic       e1_v, e2_v, e3_v, e4_v;
  out_item_t  e1, e2, e3, e4;

  function automatic logic [1:0] method_of(input logic [2:0] ok, input logic [5:0] len);
    method_of = 2'd0;
    for (int k = 2; k >= 0; k--) begin
      if (ok[k] && len >= pfx_len(2'(k))) method_of = 2'(k + 1);
    end
  endfunction

  typedef struct packed {
    phase_t     ph;
    logic [5:0] fl;
    logic [2:0] pf;
    logic [1:0] me;
    logic [3:0] hc;
    logic [3:0] nl;
    logic [5:0] nk;
    logic [2:0] se;
    logic [7:0] vc;
  } pst_t;

  typedef struct packed {
    pst_t      s;
    logic      ev;
    out_item_t e;
  } step_t;

  function automatic pst_t start_line(input pst_t s, input logic [3:0] mhl);
    pst_t r;
    r = s;
    r.nl = '0; r.nk = '1; r.se = '0; r.vc = '0;
    r.ph = (s.hc >= mhl) ? PH_DONE : PH_NAME;
    return r;
  endfunction

  function automatic step_t do_content(input pst_t s, input logic [7:0] c,
                                       input logic [7:0] mvb);
    step_t r;
    logic [7:0] uc;
    logic found;
    r.s = s; r.ev = 1'b0; r.e = '0;
    uc = (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
    found = 1'b0;
    case (s.ph)
      PH_FIRST: begin
        for (int k = 0; k < 3; k++) begin
          if (s.fl < pfx_len(2'(k)) && c != pfx_char(2'(k), s.fl)) r.s.pf[k] = 1'b0;
        end
        if (s.fl < 6'd33) r.s.fl = s.fl + 6'd1;
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          r.s.ph = PH_SKIP;
          for (int k = 0; k < 6; k++) begin
            if (!found && s.nk[k] && s.nl == hdr_len(3'(k))) begin
              found = 1'b1; r.s.se = 3'(k); r.s.ph = PH_SPACE;
            end
          end
        end else begin
          for (int k = 0; k < 6; k++) begin
            if (s.nl >= hdr_len(3'(k)) || uc != hdr_char(3'(k), s.nl)) r.s.nk[k] = 1'b0;
          end
          if (s.nl < 4'd9) r.s.nl = s.nl + 4'd1;
        end
      end
      PH_SPACE, PH_VALUE: begin
        if (!(s.ph == PH_SPACE && c == CH_SPACE)) begin
          r.s.ph = PH_VALUE;
          if (s.vc < mvb) begin
            r.ev = 1'b1;
            r.e.kind = KIND_VALUE; r.e.field_id = s.se; r.e.value_byte = c;
            r.s.vc = s.vc + 8'd1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic step_t do_line_end(input pst_t s, input logic [3:0] mhl);
    step_t r;
    pst_t t;
    r.s = s; r.ev = 1'b0; r.e = '0;
    t = s;
    if (t.hc < 4'd15) t.hc = t.hc + 4'd1;
    case (s.ph)
      PH_FIRST: begin
        r.s.me = method_of(s.pf, s.fl);
        if (r.s.me == 2'd0) r.s.ph = PH_DONE;
        else r.s = start_line(r.s, mhl);
      end
      PH_NAME: begin
        if (s.nl == 4'd0) r.s.ph = PH_DONE;
        else r.s = start_line(t, mhl);
      end
      PH_SPACE, PH_VALUE: begin
        r.ev = 1'b1; r.e.kind = KIND_END; r.e.field_id = s.se;
        r.s = start_line(t, mhl);
      end
      PH_SKIP: r.s = start_line(t, mhl);
      default: ;
    endcase
    return r;
  endfunction

  pst_t  cur;
  step_t sa, sb;
  pst_t  sc;
  logic  do_b, do_sum, sum_end;
  logic [1:0] conf;

  assign cur = '{ph: phase, fl: fl_len, pf: pfx_ok, me: meth, hc: hl_cnt,
                 nl: nm_len, nk: nm_ok, se: sel, vc: vb_cnt};

  always_comb begin
    if (cmd.eol) sa = do_line_end(cur, max_header_lines);
    else if (cmd.replay_cr) sa = do_content(cur, CH_CR, max_value_bytes);
    else sa = '{s: cur, ev: 1'b0, e: '0};
    do_b = !cmd.eol && !cmd.hold_cr;
    if (do_b) sb = do_content(sa.s, cmd.ch, max_value_bytes);
    else sb = '{s: sa.s, ev: 1'b0, e: '0};
    sc = sb.s;
    do_sum = cmd.last;
    sum_end = cmd.last && (sb.s.ph == PH_SPACE || sb.s.ph == PH_VALUE);
    if (cmd.last && sb.s.ph == PH_FIRST) sc.me = method_of(sb.s.pf, sb.s.fl);
    conf = 2'd0;
    if (sc.me != 2'd0 && cmd.is_udp && sc.fl >= 6'd14 && sc.fl <= 6'd32)
      conf = (cmd.dest_port == discovery_port) ? 2'd2 : 2'd1;
    e1_v = sa.ev; e1 = sa.e;
    e2_v = sb.ev; e2 = sb.e;
    e3_v = sum_end; e3 = '0; e3.kind = KIND_END; e3.field_id = sb.s.se;
    e4_v = do_sum; e4 = '0; e4.kind = KIND_SUM; e4.method = sc.me; e4.confidence = conf;
    if (e4_v) e4.last_result = 1'b1;
    else if (e2_v) e2.last_result = 1'b1;
    else if (e1_v) e1.last_result = 1'b1;
  end

  // result queue: up to four writes per command, one read per cycle
  out_item_t q [OUT_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic [2:0] nw;
  logic take, rd_en;
  out_item_t w0, w1, w2, w3;

  assign cmd_ready = (cnt <= (AW+1)'(OUT_DEPTH - 4));
  assign take = cmd_valid && cmd_ready;
  assign empty = (cnt == '0);
  assign out_item = q[rp];
  assign rd_en = pop && !empty;

  always_comb begin
    out_item_t lst [4];
    logic [3:0] v;
    int j;
    lst[0] = e1; lst[1] = e2; lst[2] = e3; lst[3] = e4;
    v = {e4_v, e3_v, e2_v, e1_v};
    w0 = '0; w1 = '0; w2 = '0; w3 = '0;
    j = 0;
    for (int i = 0; i < 4; i++) begin
      if (v[i]) begin
        case (j)
          0: w0 = lst[i];
          1: w1 = lst[i];
          2: w2 = lst[i];
          default: w3 = lst[i];
        endcase
        j = j + 1;
      end
    end
    nw = 3'(j);
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (nw > 3'd0) q[wp] <= w0;
      if (nw > 3'd1) q[AW'(wp + AW'(1))] <= w1;
      if (nw > 3'd2) q[AW'(wp + AW'(2))] <= w2;
      if (nw > 3'd3) q[AW'(wp + AW'(3))] <= w3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
      phase <= PH_FIRST; fl_len <= '0; pfx_ok <= '1; meth <= '0; hl_cnt <= '0;
      nm_len <= '0; nm_ok <= '1; sel <= '0; vb_cnt <= '0;
    end else begin
      if (take) begin
        wp <= wp + AW'(nw);
        if (cmd.last) begin
          phase <= PH_FIRST; fl_len <= '0; pfx_ok <= '1; meth <= '0; hl_cnt <= '0;
          nm_len <= '0; nm_ok <= '1; sel <= '0; vb_cnt <= '0;
        end else begin
          phase <= sb.s.ph; fl_len <= sb.s.fl; pfx_ok <= sb.s.pf; meth <= sb.s.me;
          hl_cnt <= sb.s.hc; nm_len <= sb.s.nl; nm_ok <= sb.s.nk; sel <= sb.s.se;
          vb_cnt <= sb.s.vc;
        end
      end
      if (rd_en) rp <= rp + AW'(1);
      cnt <= cnt + (take ? (AW+1)'(nw) : '0) - (AW+1)'(rd_en);
    end
  end

  logic st_clear;
  assign st_clear = (phase == PH_FIRST) && (fl_len == '0);

  `SSDP_ASSERT_IMP(a_cnt_bound, clk, rst, 1'b1, cnt <= (AW+1)'(OUT_DEPTH), "queue overflow")
  `SSDP_ASSERT_NEXT(a_last_clears, clk, rst, take && cmd.last, st_clear, "state not cleared")
  `SSDP_ASSERT_IMP(a_first_len, clk, rst, 1'b1, fl_len <= 6'd33, "first line too long")
endmodule
`default_nettype wire

// File: hdl/ssdp_header_stream_parser.sv
// top level of the ssdp header stream parser
// path: a byte transfer is written to the command queue, and when the back end takes it
// its results are written to the result queue, from which the result ports read
// throughput: one byte per cycle while the command queue is not full; a byte gives up
// to four results, read one per pop, and the back end stalls while more than four wait
// reset: synchronous active high rst clears parse state and queues, sets config defaults
`timescale 1ns / 1ps
`default_nettype none
module ssdp_header_stream_parser #(
  parameter int CmdDepth = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // byte input, queue style
  input  wire logic                 push,
  output logic                      full,
  input  wire ssdp_pkg::in_item_t   in_item,
  // result output, queue style
  output logic                      empty,
  input  wire logic                 pop,
  output ssdp_pkg::out_item_t       out_item,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);
  import ssdp_pkg::*;

  // configuration registers
  logic [15:0] discovery_port;
  logic [3:0]  max_header_lines;
  logic [7:0]  max_value_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      discovery_port   <= 16'd1900;
      max_header_lines <= 4'd12;
      max_value_bytes  <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PORT:  discovery_port   <= cfg_data;
        REG_LINES: max_header_lines <= cfg_data[3:0];
        REG_VALUE: max_value_bytes  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // front: cr lf pairing, each transfer becomes one command
  logic f_valid, f_ready;
  cmd_t f_cmd;
  ssdp_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .cmd_valid(f_valid), .cmd(f_cmd), .cmd_ready(f_ready)
  );

  // command queue decouples byte intake from result production
  logic b_valid, b_ready;
  cmd_t b_cmd;
  ssdp_cmd_fifo #(.Depth(CmdDepth)) u_fifo (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_data(f_cmd), .wr_ready(f_ready),
    .rd_valid(b_valid), .rd_data(b_cmd), .rd_ready(b_ready)
  );

  // back: parse state, results into the result queue
  ssdp_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(b_valid), .cmd(b_cmd), .cmd_ready(b_ready),
    .discovery_port(discovery_port), .max_header_lines(max_header_lines),
    .max_value_bytes(max_value_bytes), .empty(empty), .pop(pop), .out_item(out_item)
  );
endmodule
`default_nettype wire
